>>> src/psw_pkg.sv
// Shared types, state codes and constants of the power sequencer with watchdog.
`default_nettype none
package psw_pkg;

	// Timer and register widths.
	localparam int TMR_W = 15;
	localparam int WDT_W = 16;

	// Sequence states, numbered as the host reads them.
	typedef enum logic [3:0] {
		S_OK           = 4'd0,
		S_TURN_OFF     = 4'd1,
		S_MIN_OFF      = 4'd2,
		S_OFF          = 4'd3,
		S_TURN_ON      = 4'd4,
		S_WAIT_PG      = 4'd5,
		S_PG_STABLE    = 4'd6,
		S_STBY_DELAY   = 4'd7,
		S_WAIT_AWAKE   = 4'd8,
		S_CLK_DELAY    = 4'd9,
		S_CORE_DELAY   = 4'd10,
		S_RST_ASSERT   = 4'd11,
		S_RST_DELAY    = 4'd12,
		S_RUNNING      = 4'd13,
		S_COLD_RESET   = 4'd14,
		S_SLEEP_DECIDE = 4'd15
	} seq_state_t;

	// Host request codes.
	localparam logic [1:0] REQ_NONE = 2'd0;
	localparam logic [1:0] REQ_WARM = 2'd1;
	localparam logic [1:0] REQ_COLD = 2'd2;
	localparam logic [1:0] REQ_OFF  = 2'd3;

	// LED event codes.
	localparam logic [1:0] LED_NONE = 2'd0;
	localparam logic [1:0] LED_OFF  = 2'd1;
	localparam logic [1:0] LED_RED  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_WDT_TICKS   = 3'd0;
	localparam logic [2:0] CFG_MIN_OFF     = 3'd1;
	localparam logic [2:0] CFG_PG_TIMEOUT  = 3'd2;
	localparam logic [2:0] CFG_SLP_TIMEOUT = 3'd3;
	localparam logic [2:0] CFG_CORE_DELAY  = 3'd4;
	localparam logic [2:0] CFG_RST_PULSE   = 3'd5;
	localparam logic [2:0] CFG_STBY_PULSE  = 3'd6;
	localparam logic [2:0] CFG_SLP_DECIDE  = 3'd7;

	// Register reset values.
	localparam logic [WDT_W-1:0] RST_WDT_TICKS   = 16'hffff;
	localparam logic [TMR_W-1:0] RST_MIN_OFF     = 15'd2000;
	localparam logic [TMR_W-1:0] RST_PG_TIMEOUT  = 15'd200;
	localparam logic [TMR_W-1:0] RST_SLP_TIMEOUT = 15'd250;
	localparam logic [TMR_W-1:0] RST_CORE_DELAY  = 15'd150;
	localparam logic [TMR_W-1:0] RST_RST_PULSE   = 15'd100;
	localparam logic [TMR_W-1:0] RST_STBY_PULSE  = 15'd100;
	localparam logic [TMR_W-1:0] RST_SLP_DECIDE  = 15'd5100;

	// Fixed delays and watchdog limits.
	localparam logic [TMR_W-1:0] PWRGD_STABLE_MS   = 15'd100;
	localparam logic [TMR_W-1:0] RSMRST_DELAY_MS   = 15'd10;
	localparam logic [TMR_W-1:0] CLKPWRGD_DELAY_MS = 15'd5;
	localparam logic [WDT_W-1:0] WDT_MIN_TICKS     = 16'd1500;
	localparam logic [WDT_W-1:0] WDT_DEFAULT_TICKS = 16'd7500;
	localparam logic [WDT_W-1:0] WDT_ALL_ONES      = 16'hffff;

	// Configuration register set.
	typedef struct packed {
		logic [WDT_W-1:0] wdt_ticks;
		logic [TMR_W-1:0] min_off;
		logic [TMR_W-1:0] pg_timeout;
		logic [TMR_W-1:0] slp_timeout;
		logic [TMR_W-1:0] core_delay;
		logic [TMR_W-1:0] rst_pulse;
		logic [TMR_W-1:0] stby_pulse;
		logic [TMR_W-1:0] slp_decide;
	} cfg_t;

	// Output pin latches.
	typedef struct packed {
		logic hrst;
		logic core;
		logic clk;
		logic stby;
		logic supply;
	} lat_t;

	// Input item; the first field sits in the highest bits.
	typedef struct packed {
		logic [WDT_W-1:0] wdt_value;
		logic             wdt_load;
		logic [1:0]       host_request;
		logic             button_pressed;
		logic             host_awake;
		logic             power_good;
		logic             wdt_tick;
		logic             ms_tick;
	} in_item_t;

	// Result item; the first field sits in the highest bits.
	typedef struct packed {
		logic [WDT_W-1:0] wdt_remaining;
		logic [1:0]       led_event;
		logic             host_reset_active;
		logic             core_good;
		logic             clock_good;
		logic             standby_reset_released;
		logic             supply_on;
		logic [3:0]       failed_state;
		logic [3:0]       state_code;
	} out_item_t;

	// Actions chosen by the sequencer for one step.
	typedef struct packed {
		logic             tmr_done;
		logic             tmr_start;
		logic [TMR_W-1:0] tmr_value;
		lat_t             lat_wr;
		lat_t             lat_val;
		logic [1:0]       led;
		logic             wdt_reload;
		logic             wdt_consume;
	} act_t;

endpackage
`default_nettype wire

>>> src/psw_cfg_regs.sv
// Configuration register file of the power sequencer.
`default_nettype none
module psw_cfg_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [psw_pkg::WDT_W-1:0] cfg_wdata,
	output psw_pkg::cfg_t                  cfg
);
	import psw_pkg::*;

	cfg_t cfg_q;

	// Register writes, masked to each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wdt_ticks   <= RST_WDT_TICKS;
			cfg_q.min_off     <= RST_MIN_OFF;
			cfg_q.pg_timeout  <= RST_PG_TIMEOUT;
			cfg_q.slp_timeout <= RST_SLP_TIMEOUT;
			cfg_q.core_delay  <= RST_CORE_DELAY;
			cfg_q.rst_pulse   <= RST_RST_PULSE;
			cfg_q.stby_pulse  <= RST_STBY_PULSE;
			cfg_q.slp_decide  <= RST_SLP_DECIDE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WDT_TICKS:   cfg_q.wdt_ticks   <= cfg_wdata;
				CFG_MIN_OFF:     cfg_q.min_off     <= cfg_wdata[TMR_W-1:0];
				CFG_PG_TIMEOUT:  cfg_q.pg_timeout  <= cfg_wdata[TMR_W-1:0];
				CFG_SLP_TIMEOUT: cfg_q.slp_timeout <= cfg_wdata[TMR_W-1:0];
				CFG_CORE_DELAY:  cfg_q.core_delay  <= cfg_wdata[TMR_W-1:0];
				CFG_RST_PULSE:   cfg_q.rst_pulse   <= cfg_wdata[TMR_W-1:0];
				CFG_STBY_PULSE:  cfg_q.stby_pulse  <= cfg_wdata[TMR_W-1:0];
				CFG_SLP_DECIDE:  cfg_q.slp_decide  <= cfg_wdata[TMR_W-1:0];
				default:         cfg_q.wdt_ticks   <= cfg_q.wdt_ticks;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> src/psw_core.sv
// Sequencer state, millisecond timer, watchdog and the logic of one poll step.
`default_nettype none
module psw_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   step,
	input  psw_pkg::in_item_t  item,
	input  psw_pkg::cfg_t      cfg,
	output psw_pkg::out_item_t result
);
	import psw_pkg::*;

	seq_state_t       seq_q, seq_d, seq_case;
	logic [TMR_W-1:0] tcnt_q, tcnt_t, tcnt_d;
	logic             trun_q, trun_d;
	logic             texp_q, texp_t, texp_d;
	logic [WDT_W-1:0] wdt_q, wdt_l, wdt_d, wdt_reload_val;
	logic             pend_q, pend_t, pend_d;
	lat_t             lat_q, lat_d;
	logic             fail;
	logic [3:0]       failed;
	act_t             act;

	// Timer tick, pending watchdog tick and watchdog load ahead of the step.
	always_comb begin
		tcnt_t = tcnt_q;
		texp_t = texp_q;
		if (item.ms_tick && trun_q && !texp_q) begin
			if (tcnt_q <= TMR_W'(1)) begin
				tcnt_t = '0;
				texp_t = 1'b1;
			end else begin
				tcnt_t = tcnt_q - TMR_W'(1);
			end
		end
		pend_t = pend_q | item.wdt_tick;
		wdt_l  = item.wdt_load ? item.wdt_value : wdt_q;
	end

	// Watchdog reload value; out-of-range settings select the default.
	assign wdt_reload_val = (cfg.wdt_ticks == WDT_ALL_ONES || cfg.wdt_ticks < WDT_MIN_TICKS)
		? WDT_DEFAULT_TICKS : cfg.wdt_ticks;

	// Next state and the actions of this step.
	always_comb begin
		seq_case = seq_q;
		fail     = 1'b0;
		act      = '0;
		unique case (seq_q)
			S_TURN_OFF: begin
				act.lat_wr    = '{hrst: 1'b0, core: 1'b1, clk: 1'b1, stby: 1'b1, supply: 1'b1};
				act.led       = LED_OFF;
				act.tmr_start = 1'b1;
				act.tmr_value = cfg.min_off;
				seq_case      = S_MIN_OFF;
			end
			S_MIN_OFF: begin
				if (texp_t) begin
					act.tmr_done = 1'b1;
					seq_case     = S_OFF;
				end
			end
			S_OFF: begin
				if (item.button_pressed) begin
					seq_case = S_TURN_ON;
				end
			end
			S_TURN_ON: begin
				act.lat_wr    = '{hrst: 1'b0, core: 1'b1, clk: 1'b1, stby: 1'b1, supply: 1'b1};
				act.lat_val   = '{hrst: 1'b0, core: 1'b0, clk: 1'b0, stby: 1'b0, supply: 1'b1};
				act.led       = LED_RED;
				act.tmr_start = 1'b1;
				act.tmr_value = cfg.pg_timeout;
				seq_case      = S_WAIT_PG;
			end
			S_WAIT_PG: begin
				if (item.power_good) begin
					act.tmr_start = 1'b1;
					act.tmr_value = PWRGD_STABLE_MS;
					seq_case      = S_PG_STABLE;
				end else if (texp_t) begin
					act.tmr_done = 1'b1;
					fail         = 1'b1;
				end
			end
			S_PG_STABLE: begin
				if (texp_t) begin
					act.tmr_done  = 1'b1;
					act.tmr_start = 1'b1;
					act.tmr_value = RSMRST_DELAY_MS;
					seq_case      = S_STBY_DELAY;
				end else if (!item.power_good) begin
					seq_case = S_WAIT_PG;
				end
			end
			S_STBY_DELAY: begin
				if (texp_t) begin
					act.tmr_done     = 1'b1;
					act.lat_wr.stby  = 1'b1;
					act.lat_val.stby = 1'b1;
					act.tmr_start    = 1'b1;
					act.tmr_value    = cfg.slp_timeout;
					seq_case         = S_WAIT_AWAKE;
				end
			end
			S_WAIT_AWAKE: begin
				if (texp_t) begin
					act.tmr_done = 1'b1;
					fail         = 1'b1;
				end else if (item.host_awake) begin
					act.tmr_start = 1'b1;
					act.tmr_value = CLKPWRGD_DELAY_MS;
					seq_case      = S_CLK_DELAY;
				end
			end
			S_CLK_DELAY: begin
				if (texp_t) begin
					act.tmr_done    = 1'b1;
					act.lat_wr.clk  = 1'b1;
					act.lat_val.clk = 1'b1;
					act.tmr_start   = 1'b1;
					act.tmr_value   = cfg.core_delay;
					seq_case        = S_CORE_DELAY;
				end
			end
			S_CORE_DELAY: begin
				if (texp_t) begin
					act.tmr_done     = 1'b1;
					act.lat_wr.core  = 1'b1;
					act.lat_val.core = 1'b1;
					act.wdt_reload   = 1'b1;
					seq_case         = S_RUNNING;
				end
			end
			S_RST_ASSERT: begin
				act.lat_wr.hrst  = 1'b1;
				act.lat_val.hrst = 1'b1;
				act.led          = LED_RED;
				act.tmr_start    = 1'b1;
				act.tmr_value    = cfg.rst_pulse;
				seq_case         = S_RST_DELAY;
			end
			S_RST_DELAY: begin
				if (texp_t) begin
					act.tmr_done    = 1'b1;
					act.lat_wr.hrst = 1'b1;
					act.wdt_reload  = 1'b1;
					seq_case        = S_RUNNING;
				end
			end
			S_RUNNING: begin
				if (item.button_pressed) begin
					seq_case = S_RST_ASSERT;
				end
				// Apart from a load of zero, the watchdog only reaches zero here when a pending tick takes it from one.
				if (wdt_l != '0) begin
					act.wdt_consume = pend_t;
					if (pend_t && wdt_l == WDT_W'(1)) begin
						seq_case = S_COLD_RESET;
					end
				end
			end
			S_COLD_RESET: begin
				act.lat_wr.stby = 1'b1;
				act.led         = LED_RED;
				act.tmr_start   = 1'b1;
				act.tmr_value   = cfg.stby_pulse;
				seq_case        = S_STBY_DELAY;
			end
			S_SLEEP_DECIDE: begin
				if (texp_t) begin
					act.tmr_done = 1'b1;
					seq_case     = item.host_awake ? S_COLD_RESET : S_TURN_OFF;
				end
			end
			default: begin
				// The idle code is not a valid sequence state.
				fail = 1'b1;
			end
		endcase

		// Power good loss late in the sequence, then host sleep entry.
		if (!fail && seq_case >= S_STBY_DELAY && !item.power_good) begin
			fail = 1'b1;
		end
		if (!fail && seq_case >= S_CLK_DELAY && seq_case != S_SLEEP_DECIDE
				&& !item.host_awake) begin
			act.tmr_start = 1'b1;
			act.tmr_value = cfg.slp_decide;
			seq_case      = S_SLEEP_DECIDE;
		end
		if (fail) begin
			seq_case = S_TURN_OFF;
		end

		// A host request overrides the state reached in the step.
		unique case (item.host_request)
			REQ_WARM: seq_d = S_RST_ASSERT;
			REQ_COLD: seq_d = S_COLD_RESET;
			REQ_OFF:  seq_d = S_TURN_OFF;
			default:  seq_d = seq_case;
		endcase
	end

	// Apply the step's actions to the timer, watchdog and pin latches.
	always_comb begin
		if (act.tmr_start) begin
			tcnt_d = act.tmr_value;
			trun_d = 1'b1;
			texp_d = 1'b0;
		end else begin
			tcnt_d = tcnt_t;
			trun_d = trun_q & ~act.tmr_done;
			texp_d = texp_t & ~act.tmr_done;
		end
		if (act.wdt_reload) begin
			wdt_d = wdt_reload_val;
		end else if (act.wdt_consume) begin
			wdt_d = wdt_l - WDT_W'(1);
		end else begin
			wdt_d = wdt_l;
		end
		pend_d = pend_t & ~act.wdt_consume;
		lat_d  = lat_t'((lat_q & ~act.lat_wr) | (act.lat_val & act.lat_wr));
		failed = fail ? seq_q : 4'd0;
	end

	// Result item of the step.
	always_comb begin
		result.state_code             = seq_d;
		result.failed_state           = failed;
		result.supply_on              = lat_d.supply;
		result.standby_reset_released = lat_d.stby;
		result.clock_good             = lat_d.clk;
		result.core_good              = lat_d.core;
		result.host_reset_active      = lat_d.hrst;
		result.led_event              = act.led;
		result.wdt_remaining          = wdt_d;
	end

	// State registers advance once per accepted step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= S_TURN_ON;
			tcnt_q <= '0;
			trun_q <= 1'b0;
			texp_q <= 1'b0;
			wdt_q  <= '0;
			pend_q <= 1'b0;
			lat_q  <= '0;
		end else if (step) begin
			seq_q  <= seq_d;
			tcnt_q <= tcnt_d;
			trun_q <= trun_d;
			texp_q <= texp_d;
			wdt_q  <= wdt_d;
			pend_q <= pend_d;
			lat_q  <= lat_d;
		end
	end

`ifndef SYNTHESIS
	// An expired timer is still marked running until the expiry is read.
	assert property (@(posedge clk) disable iff (!arst_n) texp_q |-> trun_q)
		else $error("timer expired while not running");

	// Expiry always leaves the count at zero.
	assert property (@(posedge clk) disable iff (!arst_n) texp_q |-> (tcnt_q == '0))
		else $error("timer expired with a nonzero count");

	// The sequence state moves only on an accepted step.
	assert property (@(posedge clk) disable iff (!arst_n) !step |=> $stable(seq_q))
		else $error("sequence state changed without a step");
`endif

endmodule
`default_nettype wire

>>> src/power_sequencer_with_watchdog_unit.sv
// Top level: input register, sequencer step and output register of the power sequencer.
// An accepted item moves from the input register through the step logic into the output register.
// Throughput: one poll item per cycle while m_tready holds; the step logic sits between the input and output registers.
// The input register stays ready while a result waits, as long as the output register can load.
// Reset (arst_n low, asynchronous): sequencer to turn-on, timer, watchdog and pin latches cleared,
// configuration registers to their defaults, both registers empty.
`default_nettype none
module power_sequencer_with_watchdog_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// ms_tick, wdt_tick, power_good, host_awake, button_pressed, host_request[1:0],
	// wdt_load, wdt_value[15:0]
	input  wire logic [23:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// state_code[3:0], failed_state[3:0], supply_on, standby_reset_released, clock_good,
	// core_good, host_reset_active, led_event[1:0], wdt_remaining[15:0], zero pad
	output logic [31:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	import psw_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;
	out_item_t result;
	cfg_t      cfg;
	logic      step;

	// A step runs when an item is held and the output register can take its result.
	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	psw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	psw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= in_item_t'(s_tdata);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

`ifndef SYNTHESIS
	// A held item waits in the input register until it is stepped.
	assert property (@(posedge clk) disable iff (!arst_n) valid_s1 && !step |=> valid_s1)
		else $error("input item dropped before its step");

	// Each step leaves a result in the output register.
	assert property (@(posedge clk) disable iff (!arst_n) step |=> out_valid_q)
		else $error("step without a result");
`endif

endmodule
`default_nettype wire
